>>> hw/rtl/tvm_pkg.sv
// Shared constants for the tiny register machine execute core.
`default_nettype none
package tvm_pkg;

    localparam int REG_COUNT_DEF = 4;
    localparam int INSTR_W       = 16;
    localparam int DATA_W        = 64;
    localparam int OUT_TDATA_W   = 72;
    localparam int OUT_TUSER_W   = 4;

    localparam logic [3:0] OP_HALT = 4'd0;
    localparam logic [3:0] OP_LDI  = 4'd1;
    localparam logic [3:0] OP_MOV  = 4'd2;
    localparam logic [3:0] OP_ADD  = 4'd3;
    localparam logic [3:0] OP_SUB  = 4'd4;
    localparam logic [3:0] OP_MUL  = 4'd5;
    localparam logic [3:0] OP_DIV  = 4'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIV0   = 2'd1;
    localparam logic [1:0] ST_BADREG = 2'd2;
    localparam logic [1:0] ST_HALTED = 2'd3;

endpackage
`default_nettype wire

>>> hw/rtl/tiny_register_vm_execute_core.sv
// Execute core of the tiny register machine: register file memory, ALU and result stage.
// Each transaction on the slave side is one 16-bit instruction and yields exactly one
// transaction on the master side. Instructions run one at a time: halt, load immediate,
// move, add and subtract go from the read state straight to the result stage, as do an
// unused opcode, a bad register index, a divide by zero and any instruction after halt;
// multiply first steps through its three 32x32 partial products, which share one
// multiplier; divide runs the shift-subtract divider, one quotient bit per cycle.
// The register file sits in a two-read, one-write memory whose entries read as zero
// until first written, so no clearing pass follows reset. A finished result waits in an
// output register, and the next instruction is taken while it waits; that instruction
// then holds in its last cycle until the output register is free.
`default_nettype none
module tiny_register_vm_execute_core #(
    parameter int REG_COUNT = tvm_pkg::REG_COUNT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // instruction [15:0]
    input  wire logic [tvm_pkg::INSTR_W-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // dest_index [1:0], dest_value [65:2], zero fill [71:66]
    output logic [tvm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // wrote [0], halted [1], status [3:2]
    output logic [tvm_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

    localparam int IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int MEM_DEPTH = 1 << IDX_W;
    localparam int DW        = tvm_pkg::DATA_W;
    localparam int HW        = DW / 2;
    localparam logic [4:0] REG_LIM = 5'(REG_COUNT);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DIVEND = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [DW-1:0]        r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_vld;
    logic [DW-1:0]        r_rd_a, r_rd_b;
    logic                 r_rv_a, r_rv_b;

    logic [2:0]           r_state;
    logic [15:0]          r_instr;
    logic                 r_halt;
    logic                 r_wr;
    logic [1:0]           r_status;
    logic [DW-1:0]        r_val;
    logic [DW-1:0]        r_opa, r_opb;
    logic [DW-1:0]        r_prod, r_acc;
    logic [1:0]           r_step;
    logic [DW-1:0]        r_quo, r_rem, r_dm;
    logic                 r_neg;
    logic [5:0]           r_cnt;

    logic                            r_out_valid;
    logic [tvm_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [tvm_pkg::OUT_TUSER_W-1:0] r_out_user;

    logic [3:0]    w_op, w_rd, w_ra, w_rb;
    logic [DW-1:0] w_a, w_b, w_na, w_nb;
    logic          w_bad;
    logic          w_accept, w_out_free, w_mem_we;
    logic [HW-1:0] w_mx, w_my;
    logic [DW-1:0] w_prod;
    logic [DW:0]   w_sh, w_diff;

    assign w_op = r_instr[15:12];
    assign w_rd = r_instr[11:8];
    assign w_ra = r_instr[7:4];
    assign w_rb = r_instr[3:0];

    assign w_a  = r_rv_a ? r_rd_a : '0;
    assign w_b  = r_rv_b ? r_rd_b : '0;
    assign w_na = w_a[DW-1] ? (~w_a + DW'(1'b1)) : w_a;
    assign w_nb = w_b[DW-1] ? (~w_b + DW'(1'b1)) : w_b;

    always_comb begin
        w_bad = ({1'b0, w_rd} >= REG_LIM);
        if (w_op >= tvm_pkg::OP_MOV && {1'b0, w_ra} >= REG_LIM) begin
            w_bad = 1'b1;
        end
        if (w_op >= tvm_pkg::OP_ADD && {1'b0, w_rb} >= REG_LIM) begin
            w_bad = 1'b1;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_mem_we      = (r_state == S_DONE) && w_out_free && r_wr;

    always_comb begin
        case (r_step)
            2'd0:    begin w_mx = r_opa[HW-1:0];  w_my = r_opb[HW-1:0];  end
            2'd1:    begin w_mx = r_opa[HW-1:0];  w_my = r_opb[DW-1:HW]; end
            default: begin w_mx = r_opa[DW-1:HW]; w_my = r_opb[HW-1:0];  end
        endcase
    end
    assign w_prod = {{HW{1'b0}}, w_mx} * {{HW{1'b0}}, w_my};

    assign w_sh   = {r_rem, r_quo[DW-1]};
    assign w_diff = w_sh - {1'b0, r_dm};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_a  <= r_mem[s_axis_tdata[4 +: IDX_W]];
            r_rd_b  <= r_mem[s_axis_tdata[0 +: IDX_W]];
            r_rv_a  <= r_vld[s_axis_tdata[4 +: IDX_W]];
            r_rv_b  <= r_vld[s_axis_tdata[0 +: IDX_W]];
            r_instr <= s_axis_tdata;
        end
        if (w_mem_we) begin
            r_mem[w_rd[IDX_W-1:0]] <= r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_mem_we) begin
            r_vld[w_rd[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_halt  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_wr     <= 1'b0;
                    r_status <= tvm_pkg::ST_OK;
                    r_val    <= '0;
                    r_state  <= S_DONE;
                    if (r_halt) begin
                        r_status <= tvm_pkg::ST_HALTED;
                    end else if (w_op == tvm_pkg::OP_HALT) begin
                        r_halt <= 1'b1;
                    end else if (w_op <= tvm_pkg::OP_DIV) begin
                        if (w_bad) begin
                            r_status <= tvm_pkg::ST_BADREG;
                        end else begin
                            r_wr <= 1'b1;
                            case (w_op)
                                tvm_pkg::OP_LDI: r_val <= {{(DW-8){1'b0}}, r_instr[7:0]};
                                tvm_pkg::OP_MOV: r_val <= w_a;
                                tvm_pkg::OP_ADD: r_val <= w_a + w_b;
                                tvm_pkg::OP_SUB: r_val <= w_a - w_b;
                                tvm_pkg::OP_MUL: begin
                                    r_opa   <= w_a;
                                    r_opb   <= w_b;
                                    r_step  <= 2'd0;
                                    r_state <= S_MUL;
                                end
                                default: begin
                                    if (w_b == '0) begin
                                        r_wr     <= 1'b0;
                                        r_status <= tvm_pkg::ST_DIV0;
                                    end else begin
                                        r_quo   <= w_na;
                                        r_dm    <= w_nb;
                                        r_rem   <= '0;
                                        r_neg   <= w_a[DW-1] ^ w_b[DW-1];
                                        r_cnt   <= 6'd63;
                                        r_state <= S_DIV;
                                    end
                                end
                            endcase
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= w_prod;
                    r_step <= r_step + 2'd1;
                    case (r_step)
                        2'd0:    r_acc <= '0;
                        2'd1:    r_acc <= r_prod;
                        2'd2:    r_acc <= r_acc + {r_prod[HW-1:0], {HW{1'b0}}};
                        default: begin
                            r_val   <= r_acc + {r_prod[HW-1:0], {HW{1'b0}}};
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_DIV: begin
                    if (!w_diff[DW]) begin
                        r_rem <= w_diff[DW-1:0];
                        r_quo <= {r_quo[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_sh[DW-1:0];
                        r_quo <= {r_quo[DW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_DIVEND;
                    end
                end
                S_DIVEND: begin
                    r_val   <= r_neg ? (~r_quo + DW'(1'b1)) : r_quo;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= r_wr ? {6'b0, r_val, w_rd[1:0]} : '0;
            r_out_user <= {r_status, r_halt, r_wr};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> r_out_valid)
        else $error("finished instruction did not reach the output register");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_user[0]) |-> (r_out_data == '0))
        else $error("result without a register write carries data");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");

    a_div0_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user[3:2] == tvm_pkg::ST_DIV0) |-> !r_out_user[0])
        else $error("divide by zero reported together with a write");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> ({1'b0, w_rd} < REG_LIM))
        else $error("register write beyond the register count");

endmodule
`default_nettype wire
